/* rtl/tskvf_pkg.sv */
// Shared types and constants for the two-state Kalman velocity filter.
// No dependencies.
`default_nettype none
package tskvf_pkg;

    localparam int DT_BITS = 16;

    typedef enum logic [1:0] {
        REG_PERIOD = 2'd0,
        REG_VNOISE = 2'd1,
        REG_ANOISE = 2'd2,
        REG_MNOISE = 2'd3
    } t_reg_idx;

    // operation codes for one datapath step
    typedef enum logic [4:0] {
        OP_NONE = 5'd0,
        OP_DT2 = 5'd1,
        OP_VP = 5'd2,
        OP_P00A = 5'd3,
        OP_P00B = 5'd4,
        OP_P01 = 5'd5,
        OP_P00F = 5'd6,
        OP_S = 5'd7,
        OP_DIVK0 = 5'd8,
        OP_DIVK1 = 5'd9,
        OP_Y = 5'd10,
        OP_VEL = 5'd11,
        OP_ACC = 5'd12,
        OP_CVV = 5'd13,
        OP_CVA = 5'd14,
        OP_CAV = 5'd15,
        OP_CAA = 5'd16,
        OP_LOAD = 5'd17,
        OP_WB = 5'd18
    } t_op;

    typedef struct packed {
        t_op  op;
        logic start;
    } t_cmd;

    typedef struct packed {
        logic busy;
    } t_stat;

endpackage
`default_nettype wire

/* rtl/tskvf_div.sv */
// Restoring divider, one quotient bit per cycle, numerator signed.
// Uses no package.
`default_nettype none
module tskvf_div #(
    parameter int NW = 50,
    parameter int DW = 34
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic signed [NW-1:0] i_num,
    input  wire logic [DW-1:0]        i_den,
    output logic                      o_busy,
    output logic signed [NW-1:0]      o_quot
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] r_q;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_neg;
    logic          r_busy;
    logic [DW:0]   w_sh;
    logic [DW:0]   w_sub;

    assign w_sh  = {r_rem[DW-1:0], r_q[NW-1]};
    assign w_sub = w_sh - {1'b0, r_den};
    assign o_busy = r_busy;
    assign o_quot = r_neg ? -$signed(r_q) : $signed(r_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NW);
            r_neg  <= i_num[NW-1];
            r_q    <= i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (!w_sub[DW]) begin
                r_rem <= w_sub;
                r_q   <= {r_q[NW-2:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_q   <= {r_q[NW-2:0], 1'b0};
            end
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) r_busy <= 1'b0;
        end
    end
endmodule
`default_nettype wire

/* rtl/tskvf_datapath.sv */
// Filter datapath: state, covariance, a registered shared multiplier, divider.
// Depends on tskvf_pkg and tskvf_div.
`default_nettype none
module tskvf_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire tskvf_pkg::t_cmd      i_cmd,
    output tskvf_pkg::t_stat          o_stat,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_idx,
    input  wire logic [23:0]          i_cfg_data,
    input  wire logic signed [15:0]   i_sample,
    output logic signed [31:0]        o_vel,
    output logic signed [31:0]        o_acc
);
    import tskvf_pkg::*;

    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
    localparam logic [23:0] VN_RST = 24'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam logic [23:0] AN_RST = 24'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [63:0] MN_FULL = 64'd5 << FRAC_BITS;
    localparam logic [23:0] MN_RST = MN_FULL > 64'hFFFFFF ? 24'hFFFFFF : MN_FULL[23:0];
    localparam int NW = 34 + FRAC_BITS;

    logic [15:0] r_dt;
    logic [23:0] r_vn, r_an, r_mn;
    logic signed [31:0] r_v, r_a, r_cvv, r_cva, r_cav, r_caa;
    logic signed [31:0] r_vp, r_p00, r_p01, r_p10, r_p11, r_k0, r_k1, r_y;
    logic signed [34:0] r_acc35;
    logic [16:0] r_dt2;
    logic [33:0] r_s;
    logic        r_spos;
    logic signed [15:0] r_smp;

    // one product per step, registered before use
    logic signed [33:0] w_ma;
    logic signed [32:0] w_mb;
    logic signed [66:0] w_prod;
    logic signed [66:0] r_prod;
    logic               r_prnd;
    logic [NW-1:0] w_dnum;
    logic          w_dstart;
    logic          w_dbusy;
    logic signed [NW-1:0] w_dquot;
    logic signed [66:0] w_rnd;

    function automatic logic signed [31:0] sat(input logic signed [66:0] x);
        if (x > 67'sd2147483647) return 32'sh7FFFFFFF;
        if (x < -67'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    // op selects operands for the product consumed by the next op
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (i_cmd.op)
            OP_DT2:   begin w_ma = 34'(r_dt); w_mb = 33'(r_dt); end
            OP_VP:    begin w_ma = 34'(r_a); w_mb = 33'(r_dt); end
            OP_P00A:  begin w_ma = 34'(r_cav) + 34'(r_cva); w_mb = 33'(r_dt); end
            OP_P00B:  begin w_ma = 34'(r_caa); w_mb = 33'(r_dt2); end
            OP_P01:   begin w_ma = 34'(r_caa); w_mb = 33'(r_dt); end
            OP_VEL:   begin w_ma = 34'(r_k0); w_mb = 33'(r_y); end
            OP_ACC:   begin w_ma = 34'(r_k1); w_mb = 33'(r_y); end
            OP_CVV:   begin w_ma = 34'(r_k0); w_mb = 33'(r_p00); end
            OP_CVA:   begin w_ma = 34'(r_k0); w_mb = 33'(r_p01); end
            OP_CAV:   begin w_ma = 34'(r_k1); w_mb = 33'(r_p00); end
            OP_CAA:   begin w_ma = 34'(r_k1); w_mb = 33'(r_p01); end
            default:  begin w_ma = '0; w_mb = '0; end
        endcase
    end
    assign w_prod = 67'(w_ma * w_mb);

    always_comb begin
        logic signed [66:0] t;
        int k;
        k = r_prnd ? FRAC_BITS : DT_BITS;
        t = r_prod + (67'sd1 <<< (k - 1));
        w_rnd = t >>> k;
    end

    assign w_dnum   = (i_cmd.op == OP_DIVK0) ? NW'($signed(r_p00)) <<< FRAC_BITS
                                               : NW'($signed(r_p10)) <<< FRAC_BITS;
    assign w_dstart = i_cmd.start;

    tskvf_div #(.NW(NW), .DW(34)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_dstart),
        .i_num   ($signed(w_dnum)),
        .i_den   (r_s),
        .o_busy  (w_dbusy),
        .o_quot  (w_dquot)
    );

    assign o_stat.busy = w_dbusy;
    assign o_vel = r_v;
    assign o_acc = r_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt <= 16'd655;
            r_vn <= VN_RST;
            r_an <= AN_RST;
            r_mn <= MN_RST;
            r_v <= '0; r_a <= '0;
            r_cvv <= ONE; r_cva <= '0; r_cav <= '0; r_caa <= ONE;
        end else begin
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_idx))
                    REG_PERIOD: r_dt <= i_cfg_data[15:0];
                    REG_VNOISE: r_vn <= i_cfg_data;
                    REG_ANOISE: r_an <= i_cfg_data;
                    REG_MNOISE: r_mn <= (i_cfg_data == '0) ? 24'd1 : i_cfg_data;
                    default: ;
                endcase
            end
            r_prod <= w_prod;
            r_prnd <= (i_cmd.op == OP_VEL) || (i_cmd.op == OP_ACC) ||
                      (i_cmd.op == OP_CVV) || (i_cmd.op == OP_CVA) ||
                      (i_cmd.op == OP_CAV) || (i_cmd.op == OP_CAA);
            case (i_cmd.op)
                OP_LOAD:  r_smp <= i_sample;
                // ops that use a product consume the previous op's product
                OP_VP:    r_dt2 <= w_rnd[16:0];
                OP_P00A:  r_vp <= sat(67'(r_v) + w_rnd);
                OP_P00B:  r_acc35 <= 35'(r_cvv) + 35'(w_rnd) + 35'(r_vn);
                OP_P01:   r_acc35 <= r_acc35 + 35'(w_rnd);
                OP_P00F:  begin
                    r_p01 <= sat(67'(r_cva) + w_rnd);
                    r_p10 <= sat(67'(r_cav) + w_rnd);
                    r_p11 <= sat(67'(r_caa) + 67'(r_an));
                    r_p00 <= sat(67'(r_acc35));
                end
                OP_S: begin
                    r_s    <= 34'(r_p00) + 34'(r_mn);
                    r_spos <= ($signed(35'(r_p00)) + $signed({11'd0, r_mn})) > 0;
                    r_y    <= sat(67'(sat($signed(67'(r_smp)) <<< FRAC_BITS))
                                  - 67'(r_vp));
                end
                // first quotient is final when the second division starts
                OP_DIVK1: if (i_cmd.start) r_k0 <= r_spos ? sat(67'(w_dquot)) : '0;
                OP_Y:     r_k1 <= r_spos ? sat(67'(w_dquot)) : '0;
                OP_ACC:   r_v <= sat(67'(r_vp) + w_rnd);
                OP_CVV:   r_a <= sat(67'(r_a) + w_rnd);
                OP_CVA:   r_cvv <= sat(67'(r_p00) - w_rnd);
                OP_CAV:   r_cva <= sat(67'(r_p01) - w_rnd);
                OP_CAA:   r_cav <= sat(67'(r_p10) - w_rnd);
                OP_WB:    r_caa <= sat(67'(r_p11) - w_rnd);
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

/* rtl/tskvf_ctrl.sv */
// Sequencer for predict and update steps and the handshakes.
// Depends on tskvf_pkg.
`default_nettype none
module tskvf_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output tskvf_pkg::t_cmd       o_cmd,
    input  wire tskvf_pkg::t_stat i_stat
);
    import tskvf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SEQ, ST_DIV0, ST_DIV1, ST_OUT
    } t_state;

    t_state r_st;
    t_op    r_op;
    logic   r_valid;
    logic   w_fire;

    assign w_fire  = i_valid && o_ready;
    assign o_ready = (r_st == ST_IDLE) || (r_st == ST_OUT && i_ready);
    assign o_valid = r_valid;
    assign o_cmd.op = w_fire ? OP_LOAD : r_op;
    assign o_cmd.start = ((r_st == ST_SEQ) && (r_op == OP_DIVK0)) ||
                         ((r_st == ST_DIV0) && !i_stat.busy && (r_op == OP_DIVK1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_op <= OP_NONE;
            r_valid <= 1'b0;
        end else begin
            unique case (r_st)
                ST_IDLE: begin
                    if (w_fire) begin
                        r_st <= ST_SEQ;
                        r_op <= OP_DT2;
                    end
                end
                ST_OUT: begin
                    if (i_ready) r_valid <= 1'b0;
                    if (w_fire) begin
                        r_st <= ST_SEQ;
                        r_op <= OP_DT2;
                    end else if (i_ready) begin
                        r_st <= ST_IDLE;
                    end
                end
                ST_SEQ: begin
                    unique case (r_op)
                        OP_DIVK0: begin r_st <= ST_DIV0; end
                        OP_CAA: r_op <= OP_WB;
                        OP_WB: begin
                            r_op <= OP_NONE;
                            r_st <= ST_OUT;
                            r_valid <= 1'b1;
                        end
                        default: r_op <= t_op'(r_op + 5'd1);
                    endcase
                end
                ST_DIV0: begin
                    if (!i_stat.busy) begin
                        if (r_op == OP_DIVK0) r_op <= OP_DIVK1;
                        else r_st <= ST_DIV1;
                    end
                end
                ST_DIV1: begin
                    if (!i_stat.busy) begin
                        r_op <= OP_Y;
                        r_st <= ST_SEQ;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* rtl/two_state_kalman_velocity_filter_core.sv */
// Two-state Kalman velocity filter: one encoder speed sample in, filtered
// velocity and acceleration out, Q16.16. An input beat is processed by two
// bit-serial gain divisions, one after the other, and by sequencing steps
// through one shared registered multiplier. One sample is in flight at a
// time; the next input beat can be taken in the cycle the result is taken,
// and a held-off result stalls the input. Depends on tskvf_pkg, tskvf_ctrl
// and tskvf_datapath.
`default_nettype none
module two_state_kalman_velocity_filter_core #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [15:0] i_speed_sample,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_speed_estimate,
    output logic signed [31:0]      o_accel_estimate,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [23:0]        i_cfg_data
);
    import tskvf_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    tskvf_ctrl u_ctrl (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_valid (i_valid), .o_ready (o_ready),
        .o_valid (o_valid), .i_ready (i_ready),
        .o_cmd (w_cmd), .i_stat (w_stat)
    );

    tskvf_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_cmd (w_cmd), .o_stat (w_stat),
        .i_cfg_we (i_cfg_we), .i_cfg_idx (i_cfg_idx), .i_cfg_data (i_cfg_data),
        .i_sample (i_speed_sample),
        .o_vel (o_speed_estimate), .o_acc (o_accel_estimate)
    );
endmodule
`default_nettype wire

/* test/two_state_kalman_velocity_filter_core_test.sv */
// Self-checking bench for two_state_kalman_velocity_filter_core: a directed table,
// then randomized phases under several register settings, scored against a local filter model.
// Depends on tskvf_pkg and the core RTL.
`default_nettype none
module two_state_kalman_velocity_filter_core_test;
    import tskvf_pkg::*;

    typedef struct {
        logic signed [31:0] spd;
        logic signed [31:0] acc;
    } t_est;

    typedef struct {
        logic signed [15:0] sample;
        bit                 typed;
        logic signed [31:0] spd;
        logic signed [31:0] acc;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic signed [15:0] i_speed_sample;
    logic               o_valid;
    logic               i_ready;
    logic signed [31:0] o_speed_estimate;
    logic signed [31:0] o_accel_estimate;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [23:0]        i_cfg_data;

    two_state_kalman_velocity_filter_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_speed_sample(i_speed_sample),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_speed_estimate(o_speed_estimate), .o_accel_estimate(o_accel_estimate),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    localparam int  FB = 16;
    localparam longint ONE = 64'sd1 <<< FB;
    localparam longint MAXV = 64'sd2147483647;
    localparam longint MINV = -64'sd2147483648;

    // filter model state and registers
    longint dt_r, qv_r, qa_r, r_r;
    longint m_vel, m_acc, m_cvv, m_cva, m_cav, m_caa;

    t_est est_q[$];
    t_row typed_q[$];
    int   fails;
    bit   calm;
    int   hold_req;
    int   hold_cnt;

    function automatic longint sat(longint x);
        if (x > MAXV) return MAXV;
        if (x < MINV) return MINV;
        return x;
    endfunction

    function automatic longint rnd(longint x, int k);
        return (x + (64'sd1 <<< (k - 1))) >>> k;
    endfunction

    function automatic t_est filter_step(logic signed [15:0] smp);
        longint vp, ap, dt2, p00, p01, p10, p11, s, k0, k1, meas, y;
        t_est e;
        vp = sat(m_vel + rnd(m_acc * dt_r, DT_BITS));
        ap = m_acc;
        dt2 = rnd(dt_r * dt_r, DT_BITS);
        p00 = sat(m_cvv + rnd((m_cav + m_cva) * dt_r, DT_BITS)
                  + rnd(m_caa * dt2, DT_BITS) + qv_r);
        p01 = sat(m_cva + rnd(m_caa * dt_r, DT_BITS));
        p10 = sat(m_cav + rnd(m_caa * dt_r, DT_BITS));
        p11 = sat(m_caa + qa_r);
        s = p00 + r_r;
        if (s <= 0) begin
            k0 = 0;
            k1 = 0;
        end else begin
            k0 = sat((p00 * ONE) / s);
            k1 = sat((p10 * ONE) / s);
        end
        meas = sat(longint'(smp) * ONE);
        y = sat(meas - vp);
        m_vel = sat(vp + rnd(k0 * y, FB));
        m_acc = sat(ap + rnd(k1 * y, FB));
        m_cvv = sat(p00 - rnd(k0 * p00, FB));
        m_cva = sat(p01 - rnd(k0 * p01, FB));
        m_cav = sat(p10 - rnd(k1 * p00, FB));
        m_caa = sat(p11 - rnd(k1 * p01, FB));
        e.spd = m_vel[31:0];
        e.acc = m_acc[31:0];
        return e;
    endfunction

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #30000000;
        $display("Some tests failed");
        $finish;
    end

    // receiver: random backpressure, calm stretches, long hold-off
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            i_ready <= 1'b0;
        end else if (calm) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= 35);
        end
    end

    // scoreboard
    always @(posedge i_clk) begin
        t_est e;
        t_row r;
        t_est got;
        if (i_rst_n && i_valid && o_ready) begin
            e = filter_step(i_speed_sample);
            r = typed_q.pop_front();
            if (r.typed) begin
                e.spd = r.spd;
                e.acc = r.acc;
            end
            est_q.push_back(e);
        end
        if (i_rst_n && o_valid && i_ready) begin
            got.spd = o_speed_estimate;
            got.acc = o_accel_estimate;
            if (est_q.size() == 0) begin
                $error("unexpected beat: speed_estimate %0d accel_estimate %0d",
                       got.spd, got.acc);
                fails++;
            end else begin
                e = est_q.pop_front();
                if (got.spd !== e.spd) begin
                    $error("speed_estimate expected %0d actual %0d", e.spd, got.spd);
                    fails++;
                end
                if (got.acc !== e.acc) begin
                    $error("accel_estimate expected %0d actual %0d", e.acc, got.acc);
                    fails++;
                end
            end
        end
    end

    task automatic send(logic signed [15:0] smp, bit typed, logic signed [31:0] es,
                        logic signed [31:0] ea);
        t_row r;
        int gap;
        if (!calm && $urandom_range(99) < 35) begin
            i_valid <= 1'b0;
            gap = $urandom_range(6, 1);
            repeat (gap) @(posedge i_clk);
        end
        r.sample = smp;
        r.typed = typed;
        r.spd = es;
        r.acc = ea;
        typed_q.push_back(r);
        i_valid <= 1'b1;
        i_speed_sample <= smp;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (est_q.size() != 0 || typed_q.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_reg_idx idx, logic [23:0] d);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_PERIOD: dt_r = d[15:0];
            REG_VNOISE: qv_r = d;
            REG_ANOISE: qa_r = d;
            REG_MNOISE: r_r = (d == 0) ? 1 : d;
        endcase
    endtask

    task automatic cfg_all(logic [23:0] dt, logic [23:0] qv, logic [23:0] qa, logic [23:0] r);
        cfg_write(REG_PERIOD, dt);
        cfg_write(REG_VNOISE, qv);
        cfg_write(REG_ANOISE, qa);
        cfg_write(REG_MNOISE, r);
    endtask

    t_row dir_tab[] = '{
        '{16'sd0, 1'b1, 32'sd0, 32'sd0},
        '{16'sd32767, 1'b0, 32'sd0, 32'sd0},
        '{16'sd32767, 1'b0, 32'sd0, 32'sd0},
        '{-16'sd32768, 1'b0, 32'sd0, 32'sd0},
        '{-16'sd32768, 1'b0, 32'sd0, 32'sd0},
        '{16'sd1, 1'b0, 32'sd0, 32'sd0},
        '{-16'sd1, 1'b0, 32'sd0, 32'sd0},
        '{16'sd100, 1'b0, 32'sd0, 32'sd0},
        '{16'sd200, 1'b0, 32'sd0, 32'sd0},
        '{16'sd300, 1'b0, 32'sd0, 32'sd0},
        '{16'h5555, 1'b0, 32'sd0, 32'sd0},
        '{16'shAAAA, 1'b0, 32'sd0, 32'sd0},
        '{16'sd0, 1'b0, 32'sd0, 32'sd0}
    };

    initial begin
        int ph;
        int n;
        int base;
        logic signed [15:0] smp;
        fails = 0;
        calm = 0;
        hold_req = 0;
        hold_cnt = 0;
        dt_r = 655;
        qv_r = 655;
        qa_r = 6554;
        r_r = 327680;
        m_vel = 0;
        m_acc = 0;
        m_cvv = ONE;
        m_cva = 0;
        m_cav = 0;
        m_caa = ONE;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_ready <= 1'b0;
        i_speed_sample <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i])
            send(dir_tab[i].sample, dir_tab[i].typed, dir_tab[i].spd, dir_tab[i].acc);
        drain();

        for (ph = 0; ph < 7; ph++) begin
            case (ph)
                0: cfg_all(24'h00FFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
                1: cfg_all(24'h000000, 24'h000000, 24'h000000, 24'h000000);
                2: cfg_all(24'h000001, 24'h000000, 24'h000000, 24'h000001);
                default: cfg_all(24'($urandom_range(65535)),
                                 24'($urandom_range(24'hFFFFFF)),
                                 24'($urandom_range(24'hFFFFFF)),
                                 24'($urandom_range(24'hFFFFFF)));
            endcase
            calm = (ph == 4);
            if (ph == 3) hold_req = 600;
            base = $urandom_range(2000) - 1000;
            for (n = 0; n < 172; n++) begin
                case ($urandom_range(3))
                    0: smp = 16'($urandom);
                    1: smp = ($urandom_range(1)) ? 16'sd32767 : -16'sd32768;
                    default: smp = 16'(base + n * ($urandom_range(8) - 4)
                                       + $urandom_range(40) - 20);
                endcase
                send(smp, 1'b0, 32'sd0, 32'sd0);
            end
            drain();
        end
        calm = 0;

        if (fails == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
rtl/tskvf_pkg.sv
rtl/tskvf_div.sv
rtl/tskvf_datapath.sv
rtl/tskvf_ctrl.sv
rtl/two_state_kalman_velocity_filter_core.sv
test/two_state_kalman_velocity_filter_core_test.sv
